/* hw/rtl/discount_kalman_regression_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the discount Kalman regression block
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef DISCOUNT_KALMAN_REGRESSION_TOP_DEFINES_SVH
`define DISCOUNT_KALMAN_REGRESSION_TOP_DEFINES_SVH
// Implication checked every clock, disabled in reset.
`define DKR_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
// Next-cycle implication, disabled in reset.
`define DKR_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

/* hw/rtl/dkr_pkg.sv */
// ----------------------------------------------------------------------------
// dkr_pkg
// Payload types and fixed constants of the discount Kalman regression block.
// ----------------------------------------------------------------------------
package dkr_pkg;
   localparam int DATA_W = 32;
   localparam int NUM_REGS = 8;
   localparam int NUM_DELTA = 6;
   localparam int REG_INV_SHAPE = 6;
   localparam int REG_CONF_SCALE = 7;
   localparam logic [31:0] DELTA_RST = 32'd65866;
   localparam logic [31:0] INV_SHAPE_RST = 32'd64900;
   localparam logic [31:0] CONF_SCALE_RST = 32'd669;

   typedef struct packed {
      logic signed [31:0] x_elem;
      logic signed [31:0] y_prev;
      logic               last_elem;
   } req_type;

   typedef struct packed {
      logic signed [31:0] prediction;
      logic [30:0]        variance;
   } rsp_type;
endpackage

/* hw/rtl/discount_kalman_regression_top.sv */
// ----------------------------------------------------------------------------
// discount_kalman_regression_top
// Discount-factor Kalman filter for online linear regression, fixed point.
// ----------------------------------------------------------------------------
// A non-last element beat is taken back to back while the block is idle and
// no result is pending. A last element runs a sequence on one shared
// multiplier and a one-bit-a-cycle divider, with N + 1 divides (N on the
// first step), then raises the result beat; input stalls until it is taken.
// Reset (synchronous, active high) restores registers, coefficients,
// covariance diagonal and the first-step flag; one result beat per step.
module discount_kalman_regression_top #(
   parameter int NUM_COEFFS = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dkr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dkr_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wr_data
);
   import dkr_pkg::*;
`include "discount_kalman_regression_top_defines.svh"

   localparam int N = NUM_COEFFS;
   localparam int IW = (N > 1) ? $clog2(N) : 1;
   localparam int CW = $clog2(N + 1);
   localparam int PW = (N > 1) ? $clog2(N * N) : 1;
   localparam int DIW = $clog2(NUM_DELTA);
   localparam int DIVW = 32 + FRAC_BITS + 1;
   localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;

   // The sequencer walks these phases; each multiply phase issues one
   // product per cycle into a register or a registered accumulator.
   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_PRIOR = 14'b00000000000010, // R = D P D, two products per entry
      S_V     = 14'b00000000000100, // v = R x
      S_Q     = 14'b00000000001000, // Q = x' R x + 1
      S_GAIN  = 14'b00000000010000, // K = v / Q
      S_POST  = 14'b00000000100000, // P = R - K K' Q
      S_ERR   = 14'b00000001000000, // e, e*e, ns*inv_shape
      S_EDIV  = 14'b00000010000000, // e*e / Q
      S_COEF  = 14'b00000100000000, // coeffs += prev_gain * e
      S_PRED  = 14'b00001000000000, // x . coeffs
      S_VAR   = 14'b00010000000000, // Q * ns * conf_scale
      S_OUT   = 14'b00100000000000,
      S_DIVW  = 14'b01000000000000, // divider busy
      S_SPARE = 14'b10000000000000
   } state_type;

   state_type state_ff, ret_ff;

   logic [31:0] delta_ff [NUM_DELTA];
   logic [31:0] inv_shape_ff, conf_scale_ff;
   logic signed [31:0] coef_ff [N];
   logic signed [31:0] post_ff [N*N];
   logic signed [31:0] prior_ff [N*N];
   logic signed [31:0] gain_ff [N];
   logic signed [31:0] pgain_ff [N];
   logic signed [31:0] xbuf_ff [N];
   logic signed [31:0] ns_ff, q_ff, pred_ff, y_ff, e_ff, tmp_ff, ee_ff;
   logic signed [31:0] rowsum_ff;
   logic               first_ff;
   logic [CW-1:0]      cnt_ff;
   logic [IW-1:0]      i_ff, j_ff;
   logic [1:0]         sub_ff;
   logic signed [65:0] acc_ff;
   logic signed [65:0] colacc_ff;
   logic               out_valid_ff;
   rsp_type            out_ff;

   // Shared multiplier: operands of up to 33 bits, signed.
   logic signed [32:0] ma, mb;
   logic signed [65:0] prod;
   logic [65:0]        uprod;
   logic               mneg;
   logic signed [31:0] fmul_r;

   function automatic logic signed [31:0] sat(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   always_comb begin
      logic [65:0] m;
      prod = ma * mb;
      mneg = prod[65];
      uprod = mneg ? 66'(-prod) : 66'(prod);
      m = uprod >> FRAC_BITS;
      if (mneg) begin
         if ((uprod & ((66'd1 << FRAC_BITS) - 66'd1)) != 66'd0) m = m + 66'd1;
         fmul_r = sat(-$signed(m));
      end else begin
         fmul_r = sat($signed(m));
      end
   end

   // Shared restoring divider: (a << FRAC) / b, truncated, saturated.
   logic [DIVW-1:0] dnum_ff, drem_ff;
   logic [31:0]     dden_ff;
   logic            dneg_ff, dzero_ff;
   logic [6:0]      dcnt_ff;
   logic signed [31:0] dres;
   logic            div_start;
   logic signed [31:0] div_a, div_b;

   always_comb begin
      logic [DIVW:0] qv;
      qv = {1'b0, dnum_ff};
      if (dzero_ff) dres = '0;
      else if (dneg_ff) dres = sat(-$signed({1'b0, 65'(qv)}));
      else dres = sat($signed({1'b0, 65'(qv)}));
   end

   logic [PW-1:0] pidx;
   assign pidx = PW'(i_ff) * PW'(N) + PW'(j_ff);

   logic last_i, last_j;
   assign last_i = (i_ff == IW'(N - 1));
   assign last_j = (j_ff == IW'(N - 1));

   assign req_stall = (state_ff != S_IDLE) || out_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      ma = '0;
      mb = '0;
      div_start = 1'b0;
      div_a = '0;
      div_b = q_ff;
      case (state_ff)
         S_PRIOR: begin
            if (sub_ff == 2'd0) begin
               ma = 33'(post_ff[pidx]);
               mb = {1'b0, delta_ff[DIW'(j_ff)]};
            end else begin
               ma = 33'(tmp_ff);
               mb = {1'b0, delta_ff[DIW'(i_ff)]};
            end
         end
         S_V: begin
            ma = 33'(prior_ff[pidx]);
            mb = 33'(xbuf_ff[j_ff]);
         end
         S_Q: begin
            if (sub_ff == 2'd0) begin
               ma = 33'(xbuf_ff[i_ff]);
               mb = 33'(prior_ff[pidx]);
            end else begin
               ma = 33'(rowsum_ff);
               mb = 33'(xbuf_ff[j_ff]);
            end
         end
         S_GAIN: begin
            div_start = 1'b1;
            div_a = rowsum_ff;
         end
         S_POST: begin
            if (sub_ff == 2'd0) begin
               ma = 33'(gain_ff[i_ff]);
               mb = 33'(gain_ff[j_ff]);
            end else begin
               ma = 33'(tmp_ff);
               mb = 33'(q_ff);
            end
         end
         S_ERR: begin
            if (sub_ff == 2'd0) begin
               ma = 33'(e_ff);
               mb = 33'(e_ff);
            end else begin
               ma = 33'(ns_ff);
               mb = {1'b0, inv_shape_ff};
            end
         end
         S_EDIV: begin
            div_start = 1'b1;
            div_a = ee_ff;
         end
         S_COEF: begin
            ma = 33'(pgain_ff[i_ff]);
            mb = 33'(e_ff);
         end
         S_PRED: begin
            ma = 33'(xbuf_ff[i_ff]);
            mb = 33'(coef_ff[i_ff]);
         end
         S_VAR: begin
            if (sub_ff == 2'd0) begin
               ma = 33'(q_ff);
               mb = 33'(ns_ff);
            end else begin
               ma = 33'(tmp_ff);
               mb = {1'b0, conf_scale_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff <= S_IDLE;
         for (int k = 0; k < NUM_DELTA; k++) delta_ff[k] <= DELTA_RST;
         inv_shape_ff <= INV_SHAPE_RST;
         conf_scale_ff <= CONF_SCALE_RST;
         for (int k = 0; k < N; k++) begin
            coef_ff[k] <= '0;
            xbuf_ff[k] <= '0;
         end
         for (int k = 0; k < N*N; k++)
            post_ff[k] <= ((k % (N + 1)) == 0) ? sat(66'(1000) <<< FRAC_BITS) : '0;
         ns_ff <= sat(66'(ONE_FX));
         pred_ff <= '0;
         first_ff <= 1'b1;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
         i_ff <= '0;
         j_ff <= '0;
         sub_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            if (32'(csr_index) < NUM_DELTA) delta_ff[csr_index] <= csr_wr_data;
            else if (32'(csr_index) == REG_INV_SHAPE) inv_shape_ff <= csr_wr_data;
            else if (32'(csr_index) == REG_CONF_SCALE) conf_scale_ff <= csr_wr_data;
         end
         if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         if (div_start) begin
            dneg_ff <= div_a[31] ^ div_b[31];
            dzero_ff <= (div_b == 0);
            dnum_ff <= DIVW'(div_a[31] ? -66'(div_a) : 66'(div_a)) << FRAC_BITS;
            dden_ff <= div_b[31] ? 32'(-div_b) : 32'(div_b);
            drem_ff <= '0;
            dcnt_ff <= 7'(DIVW);
            ret_ff <= state_ff;
            state_ff <= S_DIVW;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  if (32'(cnt_ff) < N) begin
                     xbuf_ff[cnt_ff[IW-1:0]] <= req_data.x_elem;
                     cnt_ff <= cnt_ff + CW'(1);
                  end
                  if (req_data.last_elem) begin
                     y_ff <= req_data.y_prev;
                     if (32'(cnt_ff) < N) begin
                        for (int k = 0; k < N; k++)
                           if (k > 32'(cnt_ff)) xbuf_ff[k] <= '0;
                     end
                     cnt_ff <= '0;
                     i_ff <= '0;
                     j_ff <= '0;
                     sub_ff <= '0;
                     state_ff <= S_PRIOR;
                  end
               end
            end
            S_PRIOR: begin
               if (sub_ff == 2'd0) begin
                  tmp_ff <= fmul_r;
                  sub_ff <= 2'd1;
               end else begin
                  prior_ff[pidx] <= fmul_r;
                  sub_ff <= 2'd0;
                  j_ff <= last_j ? '0 : j_ff + IW'(1);
                  if (last_j) begin
                     i_ff <= last_i ? '0 : i_ff + IW'(1);
                     if (last_i) begin
                        acc_ff <= '0;
                        state_ff <= S_V;
                     end
                  end
               end
            end
            S_V: begin
               acc_ff <= acc_ff + 66'(fmul_r);
               j_ff <= last_j ? '0 : j_ff + IW'(1);
               if (last_j) begin
                  gain_ff[i_ff] <= sat(acc_ff + 66'(fmul_r));
                  i_ff <= last_i ? '0 : i_ff + IW'(1);
                  acc_ff <= '0;
                  if (last_i) begin
                     acc_ff <= 66'(ONE_FX);
                     colacc_ff <= '0;
                     tmp_ff <= '0;
                     rowsum_ff <= '0;
                     state_ff <= S_Q;
                  end
               end
            end
            S_Q: begin
               // j outer, i inner; the column sum is kept exact and is
               // saturated once before it is multiplied by x[j].
               if (sub_ff == 2'd0) begin
                  colacc_ff <= colacc_ff + 66'(fmul_r);
                  if (last_i) begin
                     rowsum_ff <= sat(colacc_ff + 66'(fmul_r));
                     sub_ff <= 2'd1;
                  end else begin
                     i_ff <= i_ff + IW'(1);
                  end
               end else begin
                  acc_ff <= acc_ff + 66'(fmul_r);
                  colacc_ff <= '0;
                  rowsum_ff <= '0;
                  sub_ff <= 2'd0;
                  i_ff <= '0;
                  j_ff <= last_j ? '0 : j_ff + IW'(1);
                  if (last_j) begin
                     q_ff <= sat(acc_ff + 66'(fmul_r));
                     rowsum_ff <= gain_ff[0];
                     state_ff <= S_GAIN;
                  end
               end
            end
            S_DIVW: begin
               if (dcnt_ff != 7'd0) begin
                  logic [DIVW:0] r;
                  r = {drem_ff, dnum_ff[DIVW-1]};
                  dnum_ff <= {dnum_ff[DIVW-2:0], 1'b0};
                  if (r >= (DIVW+1)'(dden_ff)) begin
                     drem_ff <= DIVW'(r - (DIVW+1)'(dden_ff));
                     dnum_ff <= {dnum_ff[DIVW-2:0], 1'b1};
                  end else begin
                     drem_ff <= DIVW'(r);
                  end
                  dcnt_ff <= dcnt_ff - 7'd1;
               end else if (ret_ff == S_GAIN) begin
                  gain_ff[i_ff] <= dres;
                  i_ff <= last_i ? '0 : i_ff + IW'(1);
                  if (last_i) begin
                     j_ff <= '0;
                     sub_ff <= '0;
                     state_ff <= S_POST;
                  end else begin
                     rowsum_ff <= gain_ff[i_ff + IW'(1)];
                     state_ff <= S_GAIN;
                  end
               end else begin
                  ns_ff <= sat(66'(tmp_ff) + 66'(dres));
                  i_ff <= '0;
                  state_ff <= S_COEF;
               end
            end
            S_POST: begin
               if (sub_ff == 2'd0) begin
                  tmp_ff <= fmul_r;
                  sub_ff <= 2'd1;
               end else begin
                  post_ff[pidx] <= sat(66'(prior_ff[pidx]) - 66'(fmul_r));
                  sub_ff <= 2'd0;
                  j_ff <= last_j ? '0 : j_ff + IW'(1);
                  if (last_j) begin
                     i_ff <= last_i ? '0 : i_ff + IW'(1);
                     if (last_i) begin
                        e_ff <= sat(66'(y_ff) - 66'(pred_ff));
                        if (first_ff) begin
                           acc_ff <= '0;
                           state_ff <= S_PRED;
                        end else begin
                           state_ff <= S_ERR;
                        end
                     end
                  end
               end
            end
            S_ERR: begin
               if (sub_ff == 2'd0) begin
                  ee_ff <= fmul_r;
                  sub_ff <= 2'd1;
               end else begin
                  tmp_ff <= fmul_r;
                  sub_ff <= 2'd0;
                  state_ff <= S_EDIV;
               end
            end
            S_COEF: begin
               coef_ff[i_ff] <= sat(66'(coef_ff[i_ff]) + 66'(fmul_r));
               i_ff <= last_i ? '0 : i_ff + IW'(1);
               if (last_i) begin
                  acc_ff <= '0;
                  state_ff <= S_PRED;
               end
            end
            S_PRED: begin
               acc_ff <= acc_ff + 66'(fmul_r);
               i_ff <= last_i ? '0 : i_ff + IW'(1);
               if (last_i) begin
                  pred_ff <= sat(acc_ff + 66'(fmul_r));
                  for (int k = 0; k < N; k++) begin
                     pgain_ff[k] <= gain_ff[k];
                  end
                  sub_ff <= '0;
                  state_ff <= S_VAR;
               end
            end
            S_VAR: begin
               if (sub_ff == 2'd0) begin
                  tmp_ff <= fmul_r;
                  sub_ff <= 2'd1;
               end else begin
                  sub_ff <= 2'd0;
                  out_ff.prediction <= pred_ff;
                  out_ff.variance <= fmul_r[31] ? '0 : fmul_r[30:0];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               first_ff <= 1'b0;
               for (int k = 0; k < N; k++) xbuf_ff[k] <= '0;
               out_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: begin
            end
         endcase
      end
   end

   // Assertions.
   `DKR_ASSERT_IMPL(a_stall_busy, clock, reset, state_ff != S_IDLE, req_stall)
   `DKR_ASSERT_NEXT(a_out_after_step, clock, reset, state_ff == S_OUT, rsp_valid)
   `DKR_ASSERT_IMPL(a_onehot_state, clock, reset, 1'b1, $onehot(state_ff))
endmodule
